// ----- design/arp_cache_table_with_aging_macros.svh -----
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Shared concurrent assertion helpers for the ARP cache design.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_TABLE_WITH_AGING_MACROS_SVH
`define ARP_CACHE_TABLE_WITH_AGING_MACROS_SVH

// assert that an implication holds at every clock edge outside reset
`define ARP_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert that a signal stays low outside reset
`define ARP_ASSERT_NEVER(lbl, clk, rst_n, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(sig)) else $error(msg);

`endif

// ----- design/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, widths and command codes for the ARP cache with aging.
// ----------------------------------------------------------------------------
`default_nettype none
package arpc_pkg;

  localparam int Depth     = 32;
  localparam int SlotW     = $clog2(Depth);
  localparam int CountW    = 6;
  localparam int FullW     = $clog2(Depth + 1);
  localparam logic [31:0] TimeoutReset = 32'd300;

  localparam logic [2:0] CmdAdd     = 3'd0;
  localparam logic [2:0] CmdLookup  = 3'd1;
  localparam logic [2:0] CmdRemove  = 3'd2;
  localparam logic [2:0] CmdCleanup = 3'd3;
  localparam logic [2:0] CmdDump    = 3'd4;
  localparam logic [2:0] CmdClear   = 3'd5;
  localparam logic [2:0] CmdTick    = 3'd6;
  localparam logic [2:0] CmdUnused  = 3'd7;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] ip_addr;
    logic [47:0] hw_addr;
    logic        static_flag;
  } arp_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
    logic [31:0] entry_time;
    logic        entry_static;
    logic [5:0]  drop_count;
    logic [5:0]  occupancy;
    logic        last;
  } arp_rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    arp_req_t         req;
    logic             hit;
    logic [SlotW-1:0] slot;
    logic             has_free;
    logic [SlotW-1:0] free_slot;
  } arp_op_t;

  // table state exported by the back end for key matching
  typedef struct packed {
    logic [Depth-1:0] valid;
    logic             busy;
  } arp_tab_t;

endpackage
`default_nettype wire

// ----- design/arpc_front.sv -----
// ----------------------------------------------------------------------------
// ARP cache front end
// Accepts commands, matches the key against all slots and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none
module arpc_front import arpc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire arp_req_t           req_i,
  input  wire arp_tab_t           tab_i,
  input  wire logic [Depth*32-1:0] keys_i,
  output logic                    op_valid_o,
  input  wire logic               op_ready_i,
  output arp_op_t                 op_o
);

  logic    op_valid_q;
  arp_op_t op_q, op_d;
  logic    take;

  // one command in flight from here through the back end at a time
  assign req_ready_o = !op_valid_q && !tab_i.busy;
  assign take        = req_valid_i && req_ready_o;

  // parallel key match and free slot search
  always_comb begin
    op_d           = '0;
    op_d.req       = req_i;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (tab_i.valid[i] && keys_i[i*32 +: 32] == req_i.ip_addr) begin
        op_d.hit  = 1'b1;
        op_d.slot = SlotW'(i);
      end
      if (!tab_i.valid[i]) begin
        op_d.has_free  = 1'b1;
        op_d.free_slot = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (take) begin
      op_valid_q <= 1'b1;
    end else if (op_ready_i) begin
      op_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = op_valid_q;
  assign op_o       = op_q;

endmodule
`default_nettype wire

// ----- design/arpc_back.sv -----
// ----------------------------------------------------------------------------
// ARP cache back end
// Holds the table and executes commands, walking slots for cleanup and dump.
// ----------------------------------------------------------------------------
`default_nettype none
module arpc_back import arpc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [31:0]         timeout_i,
  input  wire logic                op_valid_i,
  output logic                     op_ready_o,
  input  wire arp_op_t             op_i,
  output arp_tab_t                 tab_o,
  output logic [Depth*32-1:0]      keys_o,
  output logic                     rsp_valid_o,
  input  wire logic                rsp_ready_i,
  output arp_rsp_t                 rsp_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_CLEAN, ST_DUMP, ST_OUT} state_e;

  state_e           state_q, state_d;
  logic [Depth-1:0] valid_q, valid_d;
  logic [31:0]      ip_q   [Depth];
  logic [47:0]      mac_q  [Depth];
  logic [31:0]      time_q [Depth];
  logic [Depth-1:0] stat_q;
  logic [31:0]      now_q, now_d;
  logic [FullW-1:0] count_q, count_d;
  logic [FullW-1:0] removed_q, removed_d;
  logic [FullW-1:0] emitted_q, emitted_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic             rsp_valid_q, rsp_valid_d;
  arp_rsp_t         rsp_q, rsp_d;
  logic             last_slot;
  logic             free_out;
  logic             take_op;
  logic             wr_en;
  logic [SlotW-1:0] wr_slot;
  logic [31:0]      age;

  assign free_out   = !rsp_valid_q || rsp_ready_i;
  assign op_ready_o = (state_q == ST_IDLE) && free_out;
  assign take_op    = op_valid_i && op_ready_o;
  assign last_slot  = (idx_q == SlotW'(Depth - 1));
  assign age        = now_q - time_q[idx_q];
  assign wr_en      = take_op && (op_i.req.command == CmdAdd) && (op_i.hit || op_i.has_free);
  assign wr_slot    = op_i.hit ? op_i.slot : op_i.free_slot;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      keys_o[i*32 +: 32] = ip_q[i];
    end
  end
  assign tab_o.valid = valid_q;
  assign tab_o.busy  = (state_q != ST_IDLE) || op_valid_i;

  // next state of control, valid bits, counters and response register
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    now_d       = now_q;
    count_d     = count_q;
    removed_d   = removed_q;
    emitted_d   = emitted_q;
    idx_d       = idx_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (take_op) begin
          rsp_valid_d     = 1'b1;
          rsp_d           = '0;
          rsp_d.last      = 1'b1;
          rsp_d.occupancy = CountW'(count_q);
          case (op_i.req.command)
            CmdAdd: begin
              if (op_i.hit || op_i.has_free) begin
                rsp_d.entry_ip     = op_i.req.ip_addr;
                rsp_d.entry_mac    = op_i.req.hw_addr;
                rsp_d.entry_time   = now_q;
                rsp_d.entry_static = op_i.req.static_flag;
                if (!op_i.hit) begin
                  valid_d[op_i.free_slot] = 1'b1;
                  count_d                 = count_q + 1'b1;
                  rsp_d.occupancy         = CountW'(count_q + 1'b1);
                end
              end else begin
                rsp_d.status = StatFull;
              end
            end
            CmdLookup, CmdRemove: begin
              if (op_i.hit) begin
                rsp_d.entry_ip     = ip_q[op_i.slot];
                rsp_d.entry_mac    = mac_q[op_i.slot];
                rsp_d.entry_time   = time_q[op_i.slot];
                rsp_d.entry_static = stat_q[op_i.slot];
                if (op_i.req.command == CmdRemove) begin
                  valid_d[op_i.slot] = 1'b0;
                  count_d            = count_q - 1'b1;
                  rsp_d.occupancy    = CountW'(count_q - 1'b1);
                end
              end else begin
                rsp_d.status = StatNotFound;
              end
            end
            CmdCleanup: begin
              rsp_valid_d = 1'b0;
              removed_d   = '0;
              idx_d       = '0;
              state_d     = ST_CLEAN;
            end
            CmdDump: begin
              if (count_q == '0) begin
                rsp_d.status = StatNotFound;
              end else begin
                rsp_valid_d = 1'b0;
                emitted_d   = '0;
                idx_d       = '0;
                state_d     = ST_DUMP;
              end
            end
            CmdClear: begin
              valid_d         = '0;
              count_d         = '0;
              rsp_d.occupancy = '0;
            end
            CmdTick: begin
              now_d = now_q + 32'd1;
            end
            default: begin
            end
          endcase
        end
      end
      // one slot per cycle: drop aged non-static entries
      ST_CLEAN: begin
        if (valid_q[idx_q] && !stat_q[idx_q] && age > timeout_i) begin
          valid_d[idx_q] = 1'b0;
          count_d        = count_q - 1'b1;
          removed_d      = removed_q + 1'b1;
        end
        if (last_slot) begin
          state_d = ST_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (free_out) begin
          rsp_valid_d      = 1'b1;
          rsp_d            = '0;
          rsp_d.last       = 1'b1;
          rsp_d.drop_count = CountW'(removed_q);
          rsp_d.occupancy  = CountW'(count_q);
          state_d          = ST_IDLE;
        end
      end
      // one slot per cycle, stalling while the response register is full
      ST_DUMP: begin
        if (!valid_q[idx_q] || free_out) begin
          if (valid_q[idx_q]) begin
            rsp_valid_d        = 1'b1;
            rsp_d              = '0;
            rsp_d.entry_ip     = ip_q[idx_q];
            rsp_d.entry_mac    = mac_q[idx_q];
            rsp_d.entry_time   = time_q[idx_q];
            rsp_d.entry_static = stat_q[idx_q];
            rsp_d.occupancy    = CountW'(count_q);
            rsp_d.last         = (emitted_q + 1'b1) == count_q;
            emitted_d          = emitted_q + 1'b1;
          end
          if (last_slot) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control, table valid bits, counters and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      now_q       <= '0;
      count_q     <= '0;
      removed_q   <= '0;
      emitted_q   <= '0;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      now_q       <= now_d;
      count_q     <= count_d;
      removed_q   <= removed_d;
      emitted_q   <= emitted_d;
      idx_q       <= idx_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  // payload storage written on add
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ip_q[wr_slot]   <= op_i.req.ip_addr;
      mac_q[wr_slot]  <= op_i.req.hw_addr;
      time_q[wr_slot] <= now_q;
      stat_q[wr_slot] <= op_i.req.static_flag;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire

// ----- design/arp_cache_table_with_aging.sv -----
// Add, lookup, remove, clear and tick are registered by the front end and then
// executed by the back end into its response register. A new command is accepted
// only once the back end has taken the last one and is idle again.
// Cleanup walks all Depth slots, then returns one summary response; dump walks Depth
// slots, one per cycle, holding while the output is full.
// Reset empties the table, zeroes the tick counter and sets the timeout to 300.
// ----------------------------------------------------------------------------
// ARP cache table with aging
// Keyed IPv4-to-MAC table with lookup, aging cleanup and dump.
// ----------------------------------------------------------------------------
`default_nettype none
`include "arp_cache_table_with_aging_macros.svh"
module arp_cache_table_with_aging import arpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire arp_req_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output arp_rsp_t         out_data_o
);

  logic [31:0]         timeout_q;
  logic                op_valid, op_ready;
  arp_op_t             op;
  arp_tab_t            tab;
  logic [Depth*32-1:0] keys;
  logic                occ_ok;
  logic                is_full;
  logic                occ_full;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  arpc_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .tab_i       (tab),
    .keys_i      (keys),
    .op_valid_o  (op_valid),
    .op_ready_i  (op_ready),
    .op_o        (op)
  );

  arpc_back u_back (
    .clk_i, .rst_ni,
    .timeout_i   (timeout_q),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .tab_o       (tab),
    .keys_o      (keys),
    .rsp_valid_o (out_valid_o),
    .rsp_ready_i (out_ready_i),
    .rsp_o       (out_data_o)
  );

  // helper terms for the checks below
  assign occ_ok   = out_data_o.occupancy <= CountW'(Depth);
  assign is_full  = out_data_o.status == StatFull;
  assign occ_full = out_data_o.occupancy == CountW'(Depth);

  `ARP_ASSERT_NEVER(a_no_take_busy, clk_i, rst_ni, in_ready_o && op_valid, "accept while busy")
  `ARP_ASSERT_IMPL(a_occ_range, clk_i, rst_ni, out_valid_o |-> occ_ok, "occupancy overflow")
  `ARP_ASSERT_IMPL(a_full_add, clk_i, rst_ni, out_valid_o && is_full |-> occ_full, "full with room")

endmodule
`default_nettype wire

// ----- dv/tb_arp_cache_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// ARP cache table testbench
// Drives add, lookup, remove, cleanup, dump, clear and tick transactions with
// random gaps and output stalls, predicts each response from a local copy of
// the table, and compares every response field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_arp_cache_table_with_aging import arpc_pkg::*; ();

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  arp_req_t in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  arp_rsp_t out_data_o;

  arp_cache_table_with_aging uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow table
  logic        tab_valid [Depth];
  logic [31:0] tab_ip    [Depth];
  logic [47:0] tab_mac   [Depth];
  logic [31:0] tab_time  [Depth];
  logic        tab_static[Depth];
  logic [31:0] cur_ticks;
  logic [31:0] cur_timeout;
  int          entry_count;

  arp_rsp_t rsp_queue[$];
  int       err_count = 0;
  bit       stall_on = 1'b1;

  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic arp_rsp_t make_rsp(logic [1:0] st, int slot, int rem, bit lst);
    arp_rsp_t r;
    r = '0;
    r.status = st;
    if (slot >= 0) begin
      r.entry_ip = tab_ip[slot];
      r.entry_mac = tab_mac[slot];
      r.entry_time = tab_time[slot];
      r.entry_static = tab_static[slot];
    end
    r.drop_count = rem[5:0];
    r.occupancy = entry_count[5:0];
    r.last = lst;
    return r;
  endfunction

  function automatic int find_slot(logic [31:0] ip);
    for (int i = 0; i < Depth; i++)
      if (tab_valid[i] && tab_ip[i] == ip) return i;
    return -1;
  endfunction

  // queue one expected response
  task automatic expect_rsp(arp_rsp_t r);
    rsp_queue.insert(rsp_queue.size(), r);
  endtask

  // compute expected responses for one request and update shadow state
  task automatic predict_table(arp_req_t rq);
    int s;
    int n;
    int rem;
    s = -1;
    n = 0;
    rem = 0;
    case (rq.command)
      CmdAdd: begin
        s = find_slot(rq.ip_addr);
        if (s < 0) begin
          for (int i = 0; i < Depth; i++)
            if (!tab_valid[i]) begin s = i; break; end
          if (s >= 0) begin
            tab_valid[s] = 1'b1;
            entry_count++;
          end
        end
        if (s < 0) expect_rsp(make_rsp(StatFull, -1, 0, 1'b1));
        else begin
          tab_ip[s] = rq.ip_addr;
          tab_mac[s] = rq.hw_addr;
          tab_time[s] = cur_ticks;
          tab_static[s] = rq.static_flag;
          expect_rsp(make_rsp(StatOk, s, 0, 1'b1));
        end
      end
      CmdLookup: begin
        s = find_slot(rq.ip_addr);
        expect_rsp(make_rsp(s < 0 ? StatNotFound : StatOk, s, 0, 1'b1));
      end
      CmdRemove: begin
        s = find_slot(rq.ip_addr);
        if (s >= 0) begin
          tab_valid[s] = 1'b0;
          entry_count--;
        end
        expect_rsp(make_rsp(s < 0 ? StatNotFound : StatOk, s, 0, 1'b1));
      end
      CmdCleanup: begin
        for (int i = 0; i < Depth; i++)
          if (tab_valid[i] && !tab_static[i] &&
              (cur_ticks - tab_time[i]) > cur_timeout) begin
            tab_valid[i] = 1'b0;
            entry_count--;
            rem++;
          end
        expect_rsp(make_rsp(StatOk, -1, rem, 1'b1));
      end
      CmdDump: begin
        for (int i = 0; i < Depth; i++)
          if (tab_valid[i]) begin
            expect_rsp(make_rsp(StatOk, i, 0, (n + 1) == entry_count));
            n++;
          end
        if (n == 0) expect_rsp(make_rsp(StatNotFound, -1, 0, 1'b1));
      end
      CmdClear: begin
        for (int i = 0; i < Depth; i++) tab_valid[i] = 1'b0;
        entry_count = 0;
        expect_rsp(make_rsp(StatOk, -1, 0, 1'b1));
      end
      CmdTick: begin
        cur_ticks = cur_ticks + 32'd1;
        expect_rsp(make_rsp(StatOk, -1, 0, 1'b1));
      end
      default: expect_rsp(make_rsp(StatOk, -1, 0, 1'b1));
    endcase
  endtask

  // send one request transaction; valid stays high when the next follows at once
  task automatic send_req(logic [2:0] cmd, logic [31:0] ip, logic [47:0] mac, logic st);
    arp_req_t rq;
    int gap;
    rq.command = cmd;
    rq.ip_addr = ip;
    rq.hw_addr = mac;
    rq.static_flag = st;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_table(rq);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [31:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_timeout = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // output side: random stalls, compare against oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (rsp_queue.size() == 0) begin
          $error("unexpected response %h", out_data_o);
          err_count++;
        end else begin
          arp_rsp_t e;
          e = rsp_queue.pop_front();
          if (out_data_o.status !== e.status) begin
            $error("status exp %h got %h", e.status, out_data_o.status); err_count++; end
          if (out_data_o.entry_ip !== e.entry_ip) begin
            $error("entry_ip exp %h got %h", e.entry_ip, out_data_o.entry_ip); err_count++; end
          if (out_data_o.entry_mac !== e.entry_mac) begin
            $error("entry_mac exp %h got %h", e.entry_mac, out_data_o.entry_mac);
            err_count++;
          end
          if (out_data_o.entry_time !== e.entry_time) begin
            $error("entry_time exp %h got %h", e.entry_time, out_data_o.entry_time);
            err_count++;
          end
          if (out_data_o.entry_static !== e.entry_static) begin
            $error("entry_static exp %h got %h", e.entry_static, out_data_o.entry_static);
            err_count++;
          end
          if (out_data_o.drop_count !== e.drop_count) begin
            $error("drop_count exp %0d got %0d", e.drop_count, out_data_o.drop_count);
            err_count++;
          end
          if (out_data_o.occupancy !== e.occupancy) begin
            $error("occupancy exp %0d got %0d", e.occupancy, out_data_o.occupancy);
            err_count++;
          end
          if (out_data_o.last !== e.last) begin
            $error("last exp %h got %h", e.last, out_data_o.last); err_count++; end
        end
      end
      out_ready_i <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // small key pool so hits and overwrites are common
  function automatic logic [31:0] pool_ip();
    if ($urandom_range(0, 5) == 0) return $urandom();
    return 32'hC0A8_0000 | $urandom_range(0, 40);
  endfunction

  task automatic test_directed();
    send_req(CmdDump, 32'h0, 48'h0, 1'b0);
    send_req(CmdLookup, 32'hFFFF_FFFF, 48'h0, 1'b0);
    send_req(CmdRemove, 32'h0, 48'h0, 1'b0);
    send_req(CmdAdd, 32'h0, 48'h0, 1'b0);
    send_req(CmdAdd, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_req(CmdAdd, 32'h0, 48'hA5A5_5A5A_0F0F, 1'b0);  // overwrite
    send_req(CmdLookup, 32'h0, 48'h0, 1'b0);
    send_req(CmdTick, 32'h0, 48'h0, 1'b0);
    send_req(CmdCleanup, 32'h0, 48'h0, 1'b0);
    send_req(CmdDump, 32'h0, 48'h0, 1'b0);
    send_req(CmdRemove, 32'hFFFF_FFFF, 48'h0, 1'b0);
    send_req(CmdUnused, 32'h1234_5678, 48'h1, 1'b1);
    send_req(CmdClear, 32'h0, 48'h0, 1'b0);
    send_req(CmdDump, 32'h0, 48'h0, 1'b0);
  endtask

  // fill past capacity to see table full, then dump the full table
  task automatic test_full();
    for (int i = 0; i < Depth + 2; i++)
      send_req(CmdAdd, 32'h0A00_0000 + i, {$urandom(), 16'(i)}, i[0]);
    send_req(CmdDump, 32'h0, 48'h0, 1'b0);
    send_req(CmdLookup, 32'h0A00_0005, 48'h0, 1'b0);
  endtask

  // aging: timeout zero removes everything non-static once time moves
  task automatic test_aging();
    write_timeout(32'd0);
    send_req(CmdCleanup, 32'h0, 48'h0, 1'b0);
    send_req(CmdTick, 32'h0, 48'h0, 1'b0);
    send_req(CmdCleanup, 32'h0, 48'h0, 1'b0);
    send_req(CmdDump, 32'h0, 48'h0, 1'b0);
    write_timeout(32'hFFFF_FFFF);
    send_req(CmdCleanup, 32'h0, 48'h0, 1'b0);
    send_req(CmdClear, 32'h0, 48'h0, 1'b0);
  endtask

  task automatic test_random(int count, logic [31:0] tmo);
    int r;
    write_timeout(tmo);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        send_req(CmdAdd, pool_ip(), {$urandom(), 16'($urandom())}, 1'($urandom_range(0, 1)));
      else if (r < 50) send_req(CmdLookup, pool_ip(), {$urandom(), 16'($urandom())}, 1'b0);
      else if (r < 62) send_req(CmdRemove, pool_ip(), 48'h0, 1'($urandom_range(0, 1)));
      else if (r < 82) send_req(CmdTick, $urandom(), 48'h0, 1'b0);
      else if (r < 91) send_req(CmdCleanup, 32'h0, 48'h0, 1'b0);
      else if (r < 96) send_req(CmdDump, 32'h0, 48'h0, 1'b0);
      else if (r < 98) send_req(CmdClear, 32'h0, 48'h0, 1'b0);
      else send_req(CmdUnused, $urandom(), 48'h0, 1'b1);
      if (k == count / 2) wait_idle();  // sender holds off until drained
    end
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      tab_valid[i] = 1'b0; tab_ip[i] = '0; tab_mac[i] = '0;
      tab_time[i] = '0; tab_static[i] = 1'b0;
    end
    cur_ticks = '0;
    cur_timeout = TimeoutReset;
    entry_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full();
    test_aging();
    test_random(90, 32'd5);
    test_random(90, 32'd2);
    stall_on = 1'b0;
    test_random(50, 32'd20);
    wait_idle();
    if (err_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
